### hdl/amm_pkg.sv
// ----------------------------------------------------------------------------
// amm_pkg: shared types and constants of the audio matrix mixer
// Sizes, field widths, register codes and the queue item that passes from the
// front end to the mixing engine.
// ----------------------------------------------------------------------------
package amm_pkg;

	localparam int NUM_IN      = 8;
	localparam int NUM_OUT     = 8;
	localparam int XPT         = NUM_IN * NUM_OUT;
	localparam int XPT_W       = (XPT > 1) ? $clog2(XPT) : 1;
	localparam int K_W         = (NUM_OUT > 1) ? $clog2(NUM_OUT) : 1;

	localparam int CH_W        = 3;
	localparam int GAIN_W      = 19;
	localparam int SAMP_W      = 24;
	localparam int ACC_W       = 32;
	localparam int BP_W        = 11;
	localparam int MODE_W      = 2;
	localparam int RECIP_W     = 16;
	localparam int LOG_W       = 4;
	localparam int GAIN_FRAC   = 14;
	localparam int RECIP_FRAC  = 16;

	localparam int S_TDATA_W   = 56;
	localparam int M_TDATA_W   = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int Q_DEPTH     = 4;
	localparam int Q_W         = 2;

	// Mixing modes; code 3 behaves as fast.
	localparam logic [MODE_W-1:0] MODE_SMOOTH = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FAST   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FRAME  = 2'd2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_MIXING_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLIDE_RECIP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2  = 2'd2;

	// Request kinds carried in tuser.
	localparam logic REQ_GAIN   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	localparam logic [LOG_W-1:0] LOG2_MIN = 4'd2;
	localparam logic [LOG_W-1:0] LOG2_MAX = 4'd11;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [RECIP_W-1:0] recip;
		logic [LOG_W-1:0]   log2;
	} cfg_t;

	typedef struct packed {
		logic                     is_sample;
		logic                     closes;
		logic [CH_W-1:0]          ich;
		logic [CH_W-1:0]          och;
		logic signed [GAIN_W-1:0] gain;
		logic signed [SAMP_W-1:0] sample;
	} item_t;

	function automatic logic [LOG_W-1:0] eff_log2(input logic [LOG_W-1:0] l);
		logic [LOG_W-1:0] r;
		r = l;
		if (l < LOG2_MIN) r = LOG2_MIN;
		if (l > LOG2_MAX) r = LOG2_MAX;
		return r;
	endfunction

endpackage

### hdl/audio_matrix_mixer_gain_ramp.sv
// ----------------------------------------------------------------------------
// audio_matrix_mixer_gain_ramp: 8 x 8 audio matrix mixer with gain glides
// Mixes input channel samples into output sums through a crosspoint gain
// matrix whose gains are applied directly, glided one-pole or ramped per block.
// ----------------------------------------------------------------------------
// The slave stream carries requests. tuser selects a target gain write (0) or
// an input sample (1). Input channels of one sample time arrive in order; the
// sample of the last input channel closes the sample time, and the master
// stream then carries one transfer per output channel, tlast on the last one.
// Requests that name a channel outside the matrix are dropped at the input.
// Configuration writes are taken on any cycle with cfg_we high and must only
// happen while the block is idle.
// A four-entry queue sits between the input side and the mixing engine, so
// input transfers are taken while the engine works or the output is stalled.
// A gain write is handled from the idle state. A sample runs one
// multiply-accumulate pipeline pass per output channel. Closing a sample
// time adds one output transfer per output channel, and at a glide or block
// step a sweep over all NUM_IN * NUM_OUT crosspoints. When the receiver
// stalls, the held output transfer stays and the engine waits; the queue
// fills and then tready drops. Reset clears all gains, sums, the block
// position and the registers to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
module audio_matrix_mixer_gain_ramp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// in_channel[2:0], out_channel_sel[5:3], gain_value[24:6], sample_in[48:25]
	input  logic [amm_pkg::S_TDATA_W-1:0]   s_tdata,
	// req_type[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// out_channel[2:0], sample_out[26:3]
	output logic [amm_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [amm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [amm_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import amm_pkg::*;

	cfg_t  cfg_q;
	item_t q_item;
	logic  q_valid;
	logic  q_pop;

	// Configuration registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode  <= MODE_SMOOTH;
			cfg_q.recip <= RECIP_W'(66);
			cfg_q.log2  <= LOG_W'(6);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIXING_MODE: cfg_q.mode  <= cfg_data[MODE_W-1:0];
				CFG_SLIDE_RECIP: cfg_q.recip <= cfg_data[RECIP_W-1:0];
				CFG_BLOCK_LOG2:  cfg_q.log2  <= cfg_data[LOG_W-1:0];
				default: ;
			endcase
		end
	end

	amm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	amm_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

endmodule

### hdl/amm_ram.sv
// ----------------------------------------------------------------------------
// amm_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module amm_ram #(
	parameter int WIDTH = 19,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/amm_front.sv
// ----------------------------------------------------------------------------
// amm_front: input front end
// Unpacks each transfer, drops requests that address no channel, and queues
// the rest for the mixing engine.
// ----------------------------------------------------------------------------
module amm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [amm_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,
	output logic                           q_valid,
	output amm_pkg::item_t                 q_item,
	input  logic                           q_pop
);
	import amm_pkg::*;

	item_t            mem_q [Q_DEPTH];
	logic [Q_W-1:0]   wr_ptr_q;
	logic [Q_W-1:0]   rd_ptr_q;
	logic [Q_W:0]     cnt_q;
	item_t            in_item;
	logic             keep;
	logic             push;

	always_comb begin
		in_item.is_sample = (s_tuser == REQ_SAMPLE);
		in_item.ich       = s_tdata[2:0];
		in_item.och       = s_tdata[5:3];
		in_item.gain      = s_tdata[24:6];
		in_item.sample    = s_tdata[48:25];
		in_item.closes    = (int'(in_item.ich) == NUM_IN - 1);
		if (in_item.is_sample) begin
			keep = (int'(in_item.ich) < NUM_IN);
		end else begin
			keep = (int'(in_item.ich) < NUM_IN) && (int'(in_item.och) < NUM_OUT);
		end
	end

	assign s_tready = (int'(cnt_q) < Q_DEPTH);
	assign push     = s_tvalid && s_tready && keep;
	assign q_valid  = (cnt_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + Q_W'(1);
			if (q_pop) rd_ptr_q <= rd_ptr_q + Q_W'(1);
			if (push && !q_pop) begin
				cnt_q <= cnt_q + (Q_W+1)'(1);
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - (Q_W+1)'(1);
			end
		end
	end

endmodule

### hdl/amm_back.sv
// ----------------------------------------------------------------------------
// amm_back: mixing engine
// Writes target gains, runs the multiply-accumulate pipeline over one input
// row, emits the output sums and sweeps the current gains at block steps.
// ----------------------------------------------------------------------------
module amm_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  amm_pkg::cfg_t                  cfg,
	input  logic                           q_valid,
	input  amm_pkg::item_t                 q_item,
	output logic                           q_pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [amm_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tlast
);
	import amm_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_RUN     = 6'b000010,
		ST_DRAIN   = 6'b000100,
		ST_EMIT    = 6'b001000,
		ST_SWEEP   = 6'b010000,
		ST_SWDRAIN = 6'b100000
	} state_t;

	state_t                    state_q;
	logic [K_W-1:0]            k_q;
	logic [K_W-1:0]            e_q;
	logic [XPT_W-1:0]          sw_q;
	logic [CH_W-1:0]           ich_q;
	logic                      close_q;
	logic signed [SAMP_W-1:0]  sample_q;
	logic [BP_W-1:0]           bp_q;
	logic [XPT-1:0]            tval_q;
	logic [XPT-1:0]            cval_q;
	logic signed [ACC_W-1:0]   acc_q [NUM_OUT];

	logic [LOG_W-1:0]          l_eff;
	logic [BP_W-1:0]           bmask;
	logic [BP_W-1:0]           p;
	logic                      need_sweep;

	logic                      t_we;
	logic [XPT_W-1:0]          t_waddr;
	logic [XPT_W-1:0]          rd_addr;
	logic [GAIN_W-1:0]         t_rdata;
	logic [GAIN_W-1:0]         c_rdata;
	logic                      c_we;
	logic [GAIN_W-1:0]         c_wdata;
	logic                      issue;

	// stage 1: RAM data
	logic                      v_s1, op_s1, tv_s1, cv_s1;
	logic [K_W-1:0]            k_s1;
	logic [XPT_W-1:0]          addr_s1;
	logic signed [GAIN_W-1:0]  t1, c1;
	logic signed [GAIN_W:0]    d1;
	logic signed [RECIP_W:0]   mult1;
	// stage 2: scaled difference
	logic                      v_s2, op_s2;
	logic [K_W-1:0]            k_s2;
	logic [XPT_W-1:0]          addr_s2;
	logic signed [GAIN_W-1:0]  t_s2, c_s2;
	logic signed [36:0]        prod_s2;
	logic signed [36:0]        step2, sum_sm, fr_sh, fr;
	logic signed [GAIN_W-1:0]  newc, gmac;
	// stage 3: gain in use
	logic                      v_s3;
	logic [K_W-1:0]            k_s3;
	logic signed [GAIN_W-1:0]  gain_s3;
	// stage 4: product
	logic                      v_s4;
	logic [K_W-1:0]            k_s4;
	logic signed [42:0]        prod_s4;
	logic signed [42:0]        prod_sh;

	logic [K_W-1:0]            acc_idx;
	logic signed [ACC_W-1:0]   acc_rd;
	logic signed [43:0]        asum;
	logic signed [ACC_W-1:0]   acc_new;
	logic [SAMP_W-1:0]         sat24;
	logic                      out_load;
	logic                      pipe_empty;

	logic [CH_W-1:0]           out_ch_q;
	logic [SAMP_W-1:0]         out_samp_q;
	logic                      out_last_q;
	logic                      out_valid_q;

	assign l_eff = eff_log2(cfg.log2);
	assign bmask = BP_W'((32'd1 << l_eff) - 32'd1);
	assign p     = bp_q & bmask;
	assign need_sweep = ((cfg.mode == MODE_SMOOTH) && (p[1:0] == 2'b11)) ||
	                    ((cfg.mode == MODE_FRAME) && (p == bmask));

	assign q_pop   = (state_q == ST_IDLE) && q_valid;
	assign t_we    = q_pop && !q_item.is_sample;
	assign t_waddr = XPT_W'(int'(q_item.ich) * NUM_OUT + int'(q_item.och));
	assign issue   = (state_q == ST_RUN) || (state_q == ST_SWEEP);
	assign rd_addr = (state_q == ST_SWEEP) ? sw_q :
	                 XPT_W'(int'(ich_q) * NUM_OUT + int'(k_q));

	amm_ram #(.WIDTH(GAIN_W), .DEPTH(XPT)) u_target (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(q_item.gain),
		.raddr(rd_addr), .rdata(t_rdata)
	);

	amm_ram #(.WIDTH(GAIN_W), .DEPTH(XPT)) u_current (
		.clk(clk), .we(c_we), .waddr(addr_s2), .wdata(c_wdata),
		.raddr(rd_addr), .rdata(c_rdata)
	);

	// Entries never written read as zero.
	always_comb begin
		t1    = tv_s1 ? signed'(t_rdata) : '0;
		c1    = cv_s1 ? signed'(c_rdata) : '0;
		d1    = (GAIN_W+1)'(t1) - (GAIN_W+1)'(c1);
		mult1 = op_s1 ? signed'({1'b0, cfg.recip}) :
		        signed'((RECIP_W+1)'({1'b0, p}) + (RECIP_W+1)'(1));
	end

	always_comb begin
		step2  = prod_s2 >>> RECIP_FRAC;
		sum_sm = 37'(c_s2) + step2;
		if (cfg.mode == MODE_SMOOTH && step2 != '0) begin
			newc = sum_sm[GAIN_W-1:0];
		end else begin
			newc = t_s2;
		end
		fr_sh = prod_s2 >>> l_eff;
		fr    = 37'(c_s2) + fr_sh;
		case (cfg.mode)
			MODE_SMOOTH: gmac = c_s2;
			MODE_FRAME:  gmac = fr[GAIN_W-1:0];
			default:     gmac = t_s2;
		endcase
	end

	assign c_we    = v_s2 && op_s2;
	assign c_wdata = newc;

	assign prod_sh = prod_s4 >>> GAIN_FRAC;
	assign acc_idx = (state_q == ST_EMIT) ? e_q : k_s4;
	assign acc_rd  = acc_q[acc_idx];

	always_comb begin
		asum = 44'(acc_rd) + 44'(prod_sh);
		if (asum > 44'sh0007FFFFFFF) begin
			acc_new = 32'sh7FFFFFFF;
		end else if (asum < -44'sh00080000000) begin
			acc_new = 32'sh80000000;
		end else begin
			acc_new = asum[ACC_W-1:0];
		end
		if (acc_rd > 32'sd8388607) begin
			sat24 = 24'h7FFFFF;
		end else if (acc_rd < -32'sd8388608) begin
			sat24 = 24'h800000;
		end else begin
			sat24 = acc_rd[SAMP_W-1:0];
		end
	end

	assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	assign pipe_empty = !v_s1 && !v_s2 && !v_s3 && !v_s4;

	// Datapath stage registers.
	always_ff @(posedge clk) begin
		k_s1     <= k_q;
		addr_s1  <= rd_addr;
		tv_s1    <= tval_q[rd_addr];
		cv_s1    <= cval_q[rd_addr];
		k_s2     <= k_s1;
		addr_s2  <= addr_s1;
		t_s2     <= t1;
		c_s2     <= c1;
		prod_s2  <= d1 * mult1;
		k_s3     <= k_s2;
		gain_s3  <= gmac;
		k_s4     <= k_s3;
		prod_s4  <= sample_q * gain_s3;
		if (q_pop) begin
			ich_q    <= q_item.ich;
			close_q  <= q_item.closes;
			sample_q <= q_item.sample;
		end
		if (out_load) begin
			out_ch_q   <= CH_W'(e_q);
			out_samp_q <= sat24;
			out_last_q <= (e_q == K_W'(NUM_OUT - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			e_q         <= '0;
			sw_q        <= '0;
			bp_q        <= '0;
			tval_q      <= '0;
			cval_q      <= '0;
			v_s1        <= 1'b0;
			op_s1       <= 1'b0;
			v_s2        <= 1'b0;
			op_s2       <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_OUT; i++) acc_q[i] <= '0;
		end else begin
			v_s1  <= issue;
			op_s1 <= (state_q == ST_SWEEP);
			v_s2  <= v_s1;
			op_s2 <= op_s1;
			v_s3  <= v_s2 && !op_s2;
			v_s4  <= v_s3;
			if (t_we) tval_q[t_waddr] <= 1'b1;
			if (c_we) cval_q[addr_s2] <= 1'b1;
			if (v_s4) acc_q[k_s4] <= acc_new;
			if (out_load) begin
				acc_q[e_q]  <= '0;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.is_sample) begin
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					k_q <= k_q + K_W'(1);
					if (k_q == K_W'(NUM_OUT - 1)) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (pipe_empty) begin
						e_q     <= '0;
						state_q <= close_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						e_q <= e_q + K_W'(1);
						if (e_q == K_W'(NUM_OUT - 1)) begin
							bp_q <= (p + BP_W'(1)) & bmask;
							sw_q <= '0;
							state_q <= need_sweep ? ST_SWEEP : ST_IDLE;
						end
					end
				end
				ST_SWEEP: begin
					sw_q <= sw_q + XPT_W'(1);
					if (sw_q == XPT_W'(XPT - 1)) state_q <= ST_SWDRAIN;
				end
				ST_SWDRAIN: begin
					if (!v_s1 && !v_s2) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(M_TDATA_W - SAMP_W - CH_W)'(0), out_samp_q, out_ch_q};

endmodule

### hdl/amm_checker.sv
// ----------------------------------------------------------------------------
// amm_checker: output stream checks for the matrix mixer
// Watches the output ports and checks stall hold, channel order, framing and padding.
// ----------------------------------------------------------------------------
module amm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [amm_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic                           m_tlast
);
	import amm_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_last_chan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[2:0] == CH_W'(NUM_OUT - 1))))
		else $error("tlast does not match the last output channel");

	a_chan_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> !m_tvalid ||
		(m_tdata[2:0] == ($past(m_tlast) ? 3'd0 : $past(m_tdata[2:0]) + 3'd1)))
		else $error("output channels out of order");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_TDATA_W-1:SAMP_W+CH_W] == '0))
		else $error("tdata padding not zero");

endmodule

bind audio_matrix_mixer_gain_ramp amm_checker u_amm_checker (.*);

### verif/tb_audio_matrix_mixer_gain_ramp.sv
// ----------------------------------------------------------------------------
// tb_audio_matrix_mixer_gain_ramp: self-checking bench of the matrix mixer
// Streams gain writes and input samples into the mixer under several mode,
// glide and block-length settings. A local model of the gain matrix predicts
// every output transfer, and the output stream is checked in order.
// ----------------------------------------------------------------------------
module tb_audio_matrix_mixer_gain_ramp;
	timeunit 1ns;
	timeprecision 1ps;
	import amm_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 300;

	// One request as the source queue holds it.
	typedef struct {
		logic                     req;
		logic [CH_W-1:0]          ich;
		logic [CH_W-1:0]          och;
		logic signed [GAIN_W-1:0] gain;
		logic signed [SAMP_W-1:0] samp;
	} mix_req_t;

	// One predicted output transfer.
	typedef struct {
		logic [CH_W-1:0]          och;
		logic signed [SAMP_W-1:0] samp;
		logic                     last;
	} mix_out_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tlast;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	audio_matrix_mixer_gain_ramp dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Requests waiting for the driver, and output transfers still owed by the mixer.
	mix_req_t req_q[$];
	mix_out_t mix_out_q[$];
	mix_req_t held_req;
	logic     held_taken;

	// Shadow of the mixer: gain matrix, output sums, block position and registers.
	longint   tgt_gain[XPT];
	longint   cur_gain[XPT];
	longint   out_sum[NUM_OUT];
	int       blk_pos;
	int       mode_reg;
	int       recip_reg;
	int       log2_reg;

	int       src_idle;
	int       snk_idle;
	int       mismatches;
	int       n_in;
	int       n_out;
	int       n_settings;
	int       quiet_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Block length exponent as the mixer clamps it.
	function automatic int span_log2();
		if (log2_reg < 2) return 2;
		if (log2_reg > 11) return 11;
		return log2_reg;
	endfunction

	// Gain applied to crosspoint idx during the current sample time.
	function automatic longint applied_gain(int idx);
		int L;
		longint p;
		L = span_log2();
		p = blk_pos & ((1 << L) - 1);
		if (mode_reg == 0) return cur_gain[idx];
		if (mode_reg == 2) return cur_gain[idx] + (((tgt_gain[idx] - cur_gain[idx]) * (p + 1)) >>> L);
		return tgt_gain[idx];
	endfunction

	// Advances the glide or ramp at the close of a sample time.
	task automatic step_gains();
		int L;
		int bmask;
		int p;
		longint d;
		longint stp;
		L = span_log2();
		bmask = (1 << L) - 1;
		p = blk_pos & bmask;
		if (mode_reg == 0 && (p & 3) == 3) begin
			for (int i = 0; i < XPT; i++) begin
				d = tgt_gain[i] - cur_gain[i];
				stp = (d * recip_reg) >>> RECIP_FRAC;
				if (stp == 0) cur_gain[i] = tgt_gain[i];
				else cur_gain[i] = cur_gain[i] + stp;
			end
		end else if (mode_reg == 2 && p == bmask) begin
			for (int i = 0; i < XPT; i++) cur_gain[i] = tgt_gain[i];
		end
		blk_pos = (p + 1) & bmask;
	endtask

	// Works out what one accepted request causes and queues the output transfers.
	task automatic mix_predict(mix_req_t r);
		longint a;
		longint prod;
		mix_out_t o;
		if (r.req == REQ_GAIN) begin
			if (r.ich < NUM_IN && r.och < NUM_OUT) tgt_gain[r.ich * NUM_OUT + r.och] = r.gain;
			return;
		end
		if (r.ich >= NUM_IN) return;
		for (int k = 0; k < NUM_OUT; k++) begin
			prod = (longint'(r.samp) * applied_gain(r.ich * NUM_OUT + k)) >>> GAIN_FRAC;
			a = out_sum[k] + prod;
			if (a > 64'sd2147483647) a = 64'sd2147483647;
			if (a < -64'sd2147483648) a = -64'sd2147483648;
			out_sum[k] = a;
		end
		if (r.ich != NUM_IN - 1) return;
		for (int k = 0; k < NUM_OUT; k++) begin
			a = out_sum[k];
			if (a > 8388607) a = 8388607;
			if (a < -8388608) a = -8388608;
			o.och = CH_W'(k);
			o.samp = SAMP_W'(a);
			o.last = (k == NUM_OUT - 1);
			mix_out_q.push_back(o);
			out_sum[k] = 0;
		end
		step_gains();
	endtask

	// Driver: a request stays on the bus until its transfer, then the next may follow.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !held_taken) begin
				// Hold the current request.
			end else if (req_q.size() > 0 && $urandom_range(99) >= src_idle) begin
				held_req = req_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= held_req.req;
				s_tdata  <= {7'b0, held_req.samp, held_req.gain, held_req.och, held_req.ich};
			end else begin
				s_tvalid <= 1'b0;
			end
			m_tready <= ($urandom_range(99) >= snk_idle);
		end
	end

	// Monitor: predicts on each input transfer and checks each output transfer.
	always @(posedge clk) begin
		mix_out_t e;
		logic     moved;
		moved = 1'b0;
		if (arst_n) begin
			held_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				mix_predict(held_req);
				n_in++;
				moved = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				n_out++;
				moved = 1'b1;
				if (mix_out_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected output transfer ch %0d sample %0d last %0b",
							m_tdata[2:0], $signed(m_tdata[26:3]), m_tlast);
				end else begin
					e = mix_out_q.pop_front();
					if (m_tdata[2:0] !== e.och || m_tdata[26:3] !== e.samp || m_tlast !== e.last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR: output ch %0d sample %0d last %0b, expected ch %0d sample %0d last %0b",
								m_tdata[2:0], $signed(m_tdata[26:3]), m_tlast,
								e.och, e.samp, e.last);
					end
				end
			end
			// The watchdog counts cycles in which no transfer happens on either side.
			if (moved) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout after %0d cycles without a transfer", quiet_cycles);
				$display("Mismatches found");
				$finish;
			end
		end else begin
			held_taken <= 1'b0;
		end
	end

	task automatic push_req(logic req, int ich, int och, longint gain, longint samp);
		mix_req_t r;
		r.req = req;
		r.ich = CH_W'(ich);
		r.och = CH_W'(och);
		r.gain = GAIN_W'(gain);
		r.samp = SAMP_W'(samp);
		req_q.push_back(r);
	endtask

	// Gains lean toward unity-sized values so that sums do not saturate all the time.
	function automatic longint rand_gain();
		case ($urandom_range(4))
			0: return $signed(19'($urandom));
			1: return -262144 + 262143 * $urandom_range(1);
			2: return 0;
			default: return $signed(16'($urandom));
		endcase
	endfunction

	function automatic longint rand_samp();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 8388607 : -8388608;
			1: return $signed(16'($urandom));
			default: return $signed(24'($urandom));
		endcase
	endfunction

	// Random traffic: mostly whole sample times, some broken ones and some lone gain writes.
	task automatic gen_traffic(int n_items);
		int cnt;
		int r;
		int len;
		cnt = 0;
		while (cnt < n_items) begin
			r = $urandom_range(99);
			if (r < 72) begin
				for (int i = 0; i < NUM_IN; i++) begin
					if ($urandom_range(4) == 0) begin
						push_req(REQ_GAIN, $urandom_range(7), $urandom_range(7), rand_gain(), $urandom);
						cnt++;
					end
					push_req(REQ_SAMPLE, i, $urandom_range(7), $urandom, rand_samp());
					cnt++;
				end
			end else if (r < 88) begin
				// Channels skipped, repeated or out of order, then a closing sample.
				len = $urandom_range(10);
				for (int i = 0; i < len; i++)
					push_req(REQ_SAMPLE, $urandom_range(NUM_IN - 2), $urandom_range(7),
						$urandom, rand_samp());
				push_req(REQ_SAMPLE, NUM_IN - 1, $urandom_range(7), $urandom, rand_samp());
				cnt += len + 1;
			end else begin
				len = 1 + $urandom_range(3);
				for (int i = 0; i < len; i++)
					push_req(REQ_GAIN, $urandom_range(7), $urandom_range(7), rand_gain(), $urandom);
				cnt += len;
			end
		end
	endtask

	// Waits until every request is sent and every output transfer has come, then lets
	// a gain sweep and any queued gain writes finish inside the mixer.
	task automatic wait_idle();
		while (req_q.size() > 0 || s_tvalid || mix_out_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		if (idx == CFG_MIXING_MODE) mode_reg = val & 3;
		else if (idx == CFG_SLIDE_RECIP) recip_reg = val & 16'hFFFF;
		else if (idx == CFG_BLOCK_LOG2) log2_reg = val & 4'hF;
	endtask

	task automatic set_regs(logic [MODE_W-1:0] m, int recip, int l2);
		cfg_write(CFG_MIXING_MODE, m);
		cfg_write(CFG_SLIDE_RECIP, recip);
		cfg_write(CFG_BLOCK_LOG2, l2);
		@(negedge clk);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic run_phase(logic [MODE_W-1:0] m, int recip, int l2, int n_items);
		wait_idle();
		set_regs(m, recip, l2);
		gen_traffic(n_items);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < XPT; i++) begin
			tgt_gain[i] = 0;
			cur_gain[i] = 0;
		end
		for (int k = 0; k < NUM_OUT; k++) out_sum[k] = 0;
		blk_pos = 0;
		mode_reg = 0;
		recip_reg = 66;
		log2_reg = 6;
		mismatches = 0;
		n_in = 0;
		n_out = 0;
		n_settings = 0;
		quiet_cycles = 0;
		src_idle = 15;
		snk_idle = 49;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part in fast mode: gain and sample extremes, a missing channel,
		// 24-bit output saturation, and a repeated channel that drives a sum past
		// the 32-bit accumulator limit.
		set_regs(MODE_FAST, 66, 6);
		push_req(REQ_GAIN, 0, 0, 262143, 0);
		push_req(REQ_GAIN, 0, 1, -262144, 0);
		push_req(REQ_GAIN, 7, 7, 16384, -1);
		push_req(REQ_GAIN, 3, 2, -1, 8388607);
		push_req(REQ_SAMPLE, 0, 7, -1, 8388607);
		push_req(REQ_SAMPLE, 3, 0, 0, -8388608);
		push_req(REQ_SAMPLE, 7, 0, 0, -8388608);
		for (int i = 0; i < 17; i++) push_req(REQ_SAMPLE, 0, 0, 0, 8388607);
		push_req(REQ_SAMPLE, 7, 0, 0, 1);

		// Smooth glides at the fastest, zero and middle step sizes; the block length
		// runs from its lower limit to a code above the upper one.
		run_phase(MODE_SMOOTH, 65535, 2, 42);
		run_phase(MODE_SMOOTH, 0, 6, 42);
		run_phase(MODE_SMOOTH, 20000, 15, 42);
		wait_idle();
		src_idle = 49;
		snk_idle = 15;
		// Frame ramps with a block length code below the limit, a short block and the longest.
		run_phase(MODE_FRAME, 66, 0, 42);
		run_phase(MODE_FRAME, 4321, 3, 42);
		run_phase(MODE_FRAME, 65535, 11, 42);
		wait_idle();
		src_idle = 0;
		snk_idle = 0;
		// The undefined mode code, then the default glide with a mid-sized block.
		run_phase(2'd3, 0, 5, 42);
		run_phase(MODE_SMOOTH, 66, 4, 42);
		wait_idle();

		$display("Run covered %0d input and %0d output transfers under %0d register settings",
			n_in, n_out, n_settings);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches in total", mismatches);
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
